/* rtl/msp_pkg.sv */
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the matrix saddle point finder: register
// indexes, result limit and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam int ELEM_W     = 32;
  localparam int IDX_W      = 4;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COL_COUNT = 2'd1;

  localparam int RESULT_CAP = 16;
  localparam int FOUND_W    = $clog2(RESULT_CAP + 1);

  typedef struct packed {
    logic load;      // write the accepted element
    logic row_rd;    // read next element of the current row
    logic col_rd;    // read next element of the candidate column
    logic record;    // take the row verdict
    logic next_row;  // advance to the next row
    logic finish;    // place the final transaction in the output register
  } msp_cmd_t;

  typedef struct packed {
    logic load_last;  // element being loaded completes the matrix
    logic col_last;   // row read reaches the last column
    logic k_last;     // column read reaches the last row
    logic stop;       // scan ends after this row verdict
    logic ok;         // current row holds a saddle point
    logic pend_valid; // a found result waits for its successor
    logic out_free;   // output register can take a transaction
  } msp_sts_t;

endpackage

/* rtl/msp_ctrl.sv */
// ----------------------------------------------------------------------------
// msp_ctrl
// Sequencer of the saddle point finder: load, row maximum scan, column
// check and result hand-off.
// ----------------------------------------------------------------------------
module msp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  msp_pkg::msp_sts_t sts,
  output msp_pkg::msp_cmd_t cmd
);
  import msp_pkg::*;

  localparam logic [2:0] ST_LOAD   = 3'd0;
  localparam logic [2:0] ST_ROW    = 3'd1;
  localparam logic [2:0] ST_RDRAIN = 3'd2;
  localparam logic [2:0] ST_COL    = 3'd3;
  localparam logic [2:0] ST_CDRAIN = 3'd4;
  localparam logic [2:0] ST_CHECK  = 3'd5;
  localparam logic [2:0] ST_FINAL  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_LOAD);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (sts.load_last) state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row_rd = 1'b1;
        if (sts.col_last) state_nxt = ST_RDRAIN;
      end
      ST_RDRAIN: state_nxt = ST_COL;
      ST_COL: begin
        cmd.col_rd = 1'b1;
        if (sts.k_last) state_nxt = ST_CDRAIN;
      end
      ST_CDRAIN: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!(sts.ok && sts.pend_valid && !sts.out_free)) begin
          cmd.record = 1'b1;
          if (sts.stop) begin
            state_nxt = ST_FINAL;
          end else begin
            cmd.next_row = 1'b1;
            state_nxt    = ST_ROW;
          end
        end
      end
      ST_FINAL: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/msp_datapath.sv */
// ----------------------------------------------------------------------------
// msp_datapath
// Matrix store, size registers, scan counters, row maximum and column check,
// pending result and output register.
// ----------------------------------------------------------------------------
module msp_datapath #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [msp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [msp_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  logic [msp_pkg::ELEM_W-1:0]        in_data,
  input  msp_pkg::msp_cmd_t                 cmd,
  output msp_pkg::msp_sts_t                 sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [2*msp_pkg::IDX_W+msp_pkg::ELEM_W-1:0] out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import msp_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int CMPW  = CFG_DATA_W + 8;

  logic [ELEM_W-1:0]     mem [DEPTH];
  logic [CFG_DATA_W-1:0] row_cfg_r;
  logic [CFG_DATA_W-1:0] col_cfg_r;
  logic [NRW-1:0]        eff_rows;
  logic [NCW-1:0]        eff_cols;
  logic [TW-1:0]         total;
  logic [TW-1:0]         load_cnt_r;
  logic [TW-1:0]         row_base_r;
  logic [TW-1:0]         col_off_r;
  logic [TW-1:0]         rd_sum;
  logic [AW-1:0]         rd_addr;
  logic [NCW-1:0]        c_cnt_r;
  logic [NRW-1:0]        k_cnt_r;
  logic [NRW-1:0]        r_cnt_r;
  logic [FOUND_W-1:0]    found_cnt_r;
  logic [ELEM_W-1:0]     rd_data_r;
  logic                  rv_row_r;
  logic                  rv_col_r;
  logic                  rd_first_r;
  logic [NCW-1:0]        rd_col_r;
  logic signed [ELEM_W-1:0] best_r;
  logic [NCW-1:0]        bc_r;
  logic                  ok_r;
  logic                  pend_valid_r;
  logic [IDX_W-1:0]      pend_row_r;
  logic [IDX_W-1:0]      pend_col_r;
  logic [ELEM_W-1:0]     pend_val_r;
  logic                  out_valid_r;
  logic [IDX_W-1:0]      out_row_r;
  logic [IDX_W-1:0]      out_col_r;
  logic [ELEM_W-1:0]     out_val_r;
  logic                  out_found_r;
  logic                  out_last_r;
  logic                  row_last;
  logic                  scan_init;
  logic                  push_mid;
  logic                  out_free;
  logic                  cfg_hit;

  // clamp sizes to 1..MAX
  always_comb begin
    if (row_cfg_r == '0) begin
      eff_rows = NRW'(1);
    end else if (CMPW'(row_cfg_r) > CMPW'(MAX_ROWS)) begin
      eff_rows = NRW'(MAX_ROWS);
    end else begin
      eff_rows = NRW'(row_cfg_r);
    end
    if (col_cfg_r == '0) begin
      eff_cols = NCW'(1);
    end else if (CMPW'(col_cfg_r) > CMPW'(MAX_COLS)) begin
      eff_cols = NCW'(MAX_COLS);
    end else begin
      eff_cols = NCW'(col_cfg_r);
    end
  end

  assign total     = TW'(eff_rows) * TW'(eff_cols);
  assign row_last  = (r_cnt_r == eff_rows - NRW'(1));
  assign out_free  = !out_valid_r || out_tready;
  assign scan_init = cmd.load && sts.load_last;
  assign push_mid  = cmd.record && ok_r && pend_valid_r;
  assign cfg_hit   = cfg_wr_en && ((cfg_addr == REG_ROW_COUNT) || (cfg_addr == REG_COL_COUNT));

  assign rd_sum  = cmd.col_rd ? (col_off_r + TW'(bc_r)) : (row_base_r + TW'(c_cnt_r));
  assign rd_addr = rd_sum[AW-1:0];

  always_comb begin
    sts            = '0;
    sts.load_last  = (load_cnt_r == total - TW'(1));
    sts.col_last   = (c_cnt_r == eff_cols - NCW'(1));
    sts.k_last     = (k_cnt_r == eff_rows - NRW'(1));
    sts.stop       = row_last || (ok_r && (found_cnt_r == FOUND_W'(RESULT_CAP - 1)));
    sts.ok         = ok_r;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  // matrix store and registered read
  always_ff @(posedge clk) begin
    if (cmd.load) mem[load_cnt_r[AW-1:0]] <= in_data;
    rd_data_r <= mem[rd_addr];
  end

  // row maximum (first column wins ties), pending result and output register
  always_ff @(posedge clk) begin
    if (rv_row_r && (rd_first_r || ($signed(rd_data_r) > best_r))) begin
      best_r <= $signed(rd_data_r);
      bc_r   <= rd_col_r;
    end
    rd_col_r <= c_cnt_r;
    if (cmd.record && ok_r) begin
      pend_row_r <= IDX_W'(r_cnt_r);
      pend_col_r <= IDX_W'(bc_r);
      pend_val_r <= best_r;
    end
    if (push_mid) begin
      out_row_r   <= pend_row_r;
      out_col_r   <= pend_col_r;
      out_val_r   <= pend_val_r;
      out_found_r <= 1'b1;
      out_last_r  <= 1'b0;
    end else if (cmd.finish) begin
      out_row_r   <= pend_valid_r ? pend_row_r : '0;
      out_col_r   <= pend_valid_r ? pend_col_r : '0;
      out_val_r   <= pend_valid_r ? pend_val_r : '0;
      out_found_r <= pend_valid_r;
      out_last_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cfg_r    <= CFG_DATA_W'(1);
      col_cfg_r    <= CFG_DATA_W'(1);
      load_cnt_r   <= '0;
      row_base_r   <= '0;
      col_off_r    <= '0;
      c_cnt_r      <= '0;
      k_cnt_r      <= '0;
      r_cnt_r      <= '0;
      found_cnt_r  <= '0;
      rv_row_r     <= 1'b0;
      rv_col_r     <= 1'b0;
      rd_first_r   <= 1'b0;
      ok_r         <= 1'b1;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      rv_row_r   <= cmd.row_rd;
      rv_col_r   <= cmd.col_rd;
      rd_first_r <= cmd.row_rd && (c_cnt_r == '0);

      if (cfg_wr_en && (cfg_addr == REG_ROW_COUNT)) row_cfg_r <= cfg_wr_data;
      if (cfg_wr_en && (cfg_addr == REG_COL_COUNT)) col_cfg_r <= cfg_wr_data;

      if (cfg_hit || scan_init) begin
        load_cnt_r <= '0;
      end else if (cmd.load) begin
        load_cnt_r <= load_cnt_r + TW'(1);
      end

      if (scan_init || cmd.next_row) begin
        c_cnt_r   <= '0;
        k_cnt_r   <= '0;
        col_off_r <= '0;
        ok_r      <= 1'b1;
      end else begin
        if (cmd.row_rd) c_cnt_r <= c_cnt_r + NCW'(1);
        if (cmd.col_rd) begin
          k_cnt_r   <= k_cnt_r + NRW'(1);
          col_off_r <= col_off_r + TW'(eff_cols);
        end
        if (rv_col_r && ($signed(rd_data_r) < best_r)) ok_r <= 1'b0;
      end

      if (scan_init) begin
        r_cnt_r    <= '0;
        row_base_r <= '0;
      end else if (cmd.next_row) begin
        r_cnt_r    <= r_cnt_r + NRW'(1);
        row_base_r <= row_base_r + TW'(eff_cols);
      end

      if (scan_init || cmd.finish) begin
        found_cnt_r  <= '0;
        pend_valid_r <= 1'b0;
      end else if (cmd.record && ok_r) begin
        found_cnt_r  <= found_cnt_r + FOUND_W'(1);
        pend_valid_r <= 1'b1;
      end

      if (push_mid || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_col_r, out_row_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  a_pend_counted: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (found_cnt_r != '0))
    else $error("pending result without a found count");

  a_found_cap: assert property (@(posedge clk) disable iff (!rst_n)
    found_cnt_r <= FOUND_W'(RESULT_CAP))
    else $error("found count beyond result cap");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (push_mid || cmd.finish) |-> out_free)
    else $error("output register overwritten before transfer");

  a_one_read_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(rv_row_r && rv_col_r))
    else $error("row and column reads in flight together");

endmodule

/* rtl/matrix_saddle_point_finder.sv */
// ----------------------------------------------------------------------------
// matrix_saddle_point_finder
// Collects a signed matrix in row-major order and reports its saddle points.
//
// Set row_count (index 0) and col_count (index 1) on the cfg port while idle;
// a write restarts the matrix load. Sizes clamp to 1..MAX_ROWS / 1..MAX_COLS.
// in_*  : one element per transaction, one per cycle while loading.
// out_* : one transaction per saddle-point row in row order (at most 16),
//         or a single not-found transaction; tlast marks the final one.
// The load takes rows*cols elements. After the last element each row is
// scanned by a row walk and then a column walk over the single read port of
// the matrix store, each followed by a drain state for the registered read,
// and then the verdict. The final transaction is placed once the output
// register is free, then loading resumes. in_tready is low during the scan.
// A stalled receiver holds the output register; the scan pauses at a row
// verdict that needs the register until it is taken.
// Reset clears control state and sets both sizes to 1; the store needs no
// clearing.
// ----------------------------------------------------------------------------
module matrix_saddle_point_finder #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_wr_en,
  input  logic [msp_pkg::CFG_ADDR_W-1:0]               cfg_addr,
  input  logic [msp_pkg::CFG_DATA_W-1:0]               cfg_wr_data,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  input  logic [msp_pkg::ELEM_W-1:0]                   in_tdata,   // element_value
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // row_index [3:0], col_index [7:4], point_value [39:8]
  output logic [2*msp_pkg::IDX_W+msp_pkg::ELEM_W-1:0]  out_tdata,
  output logic                                         out_tuser,  // found
  output logic                                         out_tlast   // last_result
);
  import msp_pkg::*;

  msp_cmd_t cmd;
  msp_sts_t sts;

  msp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msp_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule
